FILE: hw/rtl/kmmt_pkg.sv
package kmmt_pkg;

    localparam int DATA_W      = 32;
    localparam int ENTRIES_DEF = 64;
    localparam int RECORDS_W   = 7;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MATCH,
        ST_LAUNCH,
        ST_RUN,
        ST_DONE
    } state_t;

    // Sweep token handed from cell to cell; the count travels beside it
    // because its width follows the table depth.
    typedef struct packed
    {
        logic              valid;
        logic              claim;   // free slot still wanted by a new key
        logic              any;     // a valid slot was seen so far
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
    } wave_t;

endpackage

FILE: hw/rtl/kmmt_cell.sv
module kmmt_cell #(
    parameter int CNT_W = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmp,
    input  logic [kmmt_pkg::DATA_W-1:0] ts,
    input  logic [kmmt_pkg::DATA_W-1:0] price,
    input  kmmt_pkg::wave_t             wave_in,
    input  logic [CNT_W-1:0]            cnt_in,
    output kmmt_pkg::wave_t             wave_out,
    output logic [CNT_W-1:0]            cnt_out,
    output logic                        hit
);
    import kmmt_pkg::*;

    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    logic              valid_reg;
    logic              hit_reg;
    wave_t             wave_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              take;
    logic              upd;
    logic              cur_valid;
    logic [DATA_W-1:0] cur_val;
    wave_t             wave_next;
    logic [CNT_W-1:0]  cnt_next;

    // take: a new key lands here; upd: this slot holds the key already
    assign take      = wave_in.valid & wave_in.claim & ~valid_reg;
    assign upd       = wave_in.valid & hit_reg;
    assign cur_valid = valid_reg | take;
    assign cur_val   = (take | upd) ? price : value_reg;

    always_comb
    begin
        wave_next       = wave_in;
        wave_next.claim = wave_in.claim & ~take;
        wave_next.any   = wave_in.any | cur_valid;
        cnt_next        = cnt_in;
        if (cur_valid)
        begin
            cnt_next = cnt_in + CNT_W'(1);
            if (!wave_in.any)
            begin
                wave_next.hi = cur_val;
                wave_next.lo = cur_val;
            end
            else
            begin
                if (cur_val > wave_in.hi)
                begin
                    wave_next.hi = cur_val;
                end
                if (cur_val < wave_in.lo)
                begin
                    wave_next.lo = cur_val;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            wave_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmp)
            begin
                hit_reg <= valid_reg && (key_reg == ts);
            end
            valid_reg      <= cur_valid;
            wave_reg.valid <= wave_in.valid;
            if (wave_in.valid)
            begin
                wave_reg.claim <= wave_next.claim;
                wave_reg.any   <= wave_next.any;
                wave_reg.hi    <= wave_next.hi;
                wave_reg.lo    <= wave_next.lo;
                cnt_reg        <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg <= ts;
        end
        if (take | upd)
        begin
            value_reg <= price;
        end
    end

    assign wave_out = wave_reg;
    assign cnt_out  = cnt_reg;
    assign hit      = hit_reg;

endmodule

FILE: hw/rtl/keyed_latest_max_min_tracker.sv
// Keyed price table with latest / highest / lowest tracking.
//
// Input channel (in_valid / in_stall) carries one update beat: a timestamp
// key ts and a price. The price is stored under ts, overwriting an existing
// entry with the same key; a new key takes the lowest free slot.
// Output channel (out_valid / out_stall) returns one beat per update: the
// price at the greatest key seen so far, the max and min over all stored
// prices, a dropped flag (table full, new key, nothing changed) and the
// number of stored keys.
//
// The sweep token walks the row of slot cells one cell per cycle to place
// the key and to collect max, min and count. An update is matched against
// the stored keys, launched, swept and then held until the output register
// is free; no new update is accepted before that.
//
// Reset empties the table and clears the latest-key tracker to zero.
// The result sits in an output register: a stall on the output side holds
// it stable, while the next update is still accepted and processed; that
// update then waits for the register to drain before completing.
module keyed_latest_max_min_tracker #(
    parameter int ENTRIES = kmmt_pkg::ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [kmmt_pkg::DATA_W-1:0]    ts,
    input  logic [kmmt_pkg::DATA_W-1:0]    price,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [kmmt_pkg::DATA_W-1:0]    latest_price,
    output logic [kmmt_pkg::DATA_W-1:0]    highest_price,
    output logic [kmmt_pkg::DATA_W-1:0]    lowest_price,
    output logic                           dropped,
    output logic [kmmt_pkg::RECORDS_W-1:0] records
);
    import kmmt_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    state_t            state_reg;
    state_t            state_next;

    logic [DATA_W-1:0] ts_reg;
    logic [DATA_W-1:0] price_reg;
    logic [DATA_W-1:0] newest_key_reg;
    logic [DATA_W-1:0] newest_value_reg;

    // finished sweep, parked until the output register is free
    logic [DATA_W-1:0] res_hi_reg;
    logic [DATA_W-1:0] res_lo_reg;
    logic              res_drop_reg;
    logic [CNT_W-1:0]  res_cnt_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_latest_reg;
    logic [DATA_W-1:0] out_hi_reg;
    logic [DATA_W-1:0] out_lo_reg;
    logic              out_drop_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    logic              accept;
    logic              cmp;
    logic              launch;
    logic              sweep_end;
    logic              out_load;
    logic              out_free;
    logic              drop_now;
    logic              any_hit;

    wave_t             wave [ENTRIES+1];
    logic [CNT_W-1:0]  cnt_chain [ENTRIES+1];
    logic [ENTRIES-1:0] hit_vec;
    logic [CNT_W+RECORDS_W-1:0] cnt_ext;

    assign out_free  = !out_valid_reg || !out_stall;
    assign sweep_end = wave[ENTRIES].valid;
    assign any_hit   = |hit_vec;

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:  state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_RUN;
            ST_RUN:
            begin
                if (sweep_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmp      = 1'b0;
        launch   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_MATCH:  cmp      = 1'b1;
            ST_LAUNCH: launch   = 1'b1;
            ST_RUN:    ;
            ST_DONE:   out_load = out_free;
            default:   ;
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- slot row ----------------
    // Token enters cell 0; claim is set only when no slot holds the key.
    always_comb
    begin
        wave[0]       = '0;
        wave[0].valid = launch;
        wave[0].claim = ~any_hit;
        cnt_chain[0]  = '0;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kmmt_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmp      (cmp),
            .ts       (ts_reg),
            .price    (price_reg),
            .wave_in  (wave[i]),
            .cnt_in   (cnt_chain[i]),
            .wave_out (wave[i+1]),
            .cnt_out  (cnt_chain[i+1]),
            .hit      (hit_vec[i])
        );
    end

    // claim still pending at the end: full table, new key, nothing written
    assign drop_now = wave[ENTRIES].claim;

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_key_reg   <= '0;
            newest_value_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (sweep_end && !drop_now && (ts_reg >= newest_key_reg))
            begin
                newest_key_reg   <= ts_reg;
                newest_value_reg <= price_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ts_reg    <= ts;
            price_reg <= price;
        end
        if (sweep_end)
        begin
            res_hi_reg   <= wave[ENTRIES].hi;
            res_lo_reg   <= wave[ENTRIES].lo;
            res_drop_reg <= drop_now;
            res_cnt_reg  <= cnt_chain[ENTRIES];
        end
        if (out_load)
        begin
            out_latest_reg <= newest_value_reg;
            out_hi_reg     <= res_hi_reg;
            out_lo_reg     <= res_lo_reg;
            out_drop_reg   <= res_drop_reg;
            out_cnt_reg    <= res_cnt_reg;
        end
    end

    // count reported modulo 128
    assign cnt_ext = {{RECORDS_W{1'b0}}, out_cnt_reg};

    assign out_valid     = out_valid_reg;
    assign latest_price  = out_latest_reg;
    assign highest_price = out_hi_reg;
    assign lowest_price  = out_lo_reg;
    assign dropped       = out_drop_reg;
    assign records       = cnt_ext[RECORDS_W-1:0];

endmodule
